// ----- rtl/core/quaternion_arithmetic_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit assertion macros
// Concurrent assertion wrappers used by the unit's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define QAU_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Next-cycle implication, checked outside reset.
`define QAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define QAU_ASSERT(lbl, clk, rstn, prop, msg)
`define QAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/core/qau_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Widths, mode codes, normalizer state, lane term, pass control and normalizer result types.
// ----------------------------------------------------------------------------
package qau_pkg;

	localparam int WIDTH     = 16;
	localparam int FRAC_BITS = 12;
	localparam int OPW       = WIDTH + 1;       // lane operand width
	localparam int PW        = 2 * OPW;         // lane product width
	localparam int SW        = PW + 2;          // sum of four products
	localparam int IN_W      = 9 * WIDTH;
	localparam int OUT_W     = 4 * WIDTH;
	localparam int SQW       = 2 * WIDTH + 2;   // sum of squares, even
	localparam int NR        = SQW / 2;         // root digits
	localparam int RW        = WIDTH + 3;       // root remainder
	localparam int DW        = 2 * WIDTH + 2;   // divider datapath
	localparam int QB        = FRAC_BITS + 2;   // quotient bits
	localparam int CNT_W     = $clog2(NR + 1);

	localparam logic signed [OPW-1:0] ONE = OPW'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] SUM_MAX = (SW'(1) << (WIDTH - 1)) - SW'(1);
	localparam logic signed [SW-1:0] SUM_MIN = -SUM_MAX - SW'(1);

	typedef enum logic [2:0] {
		MODE_MUL   = 3'd0,
		MODE_ADD   = 3'd1,
		MODE_SCALE = 3'd2,
		MODE_CONJ  = 3'd3,
		MODE_NORM  = 3'd4,
		MODE_MAT   = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		NS_IDLE,
		NS_SQR,
		NS_ROOT,
		NS_DIV,
		NS_DONE
	} norm_state_t;

	typedef struct packed {
		logic signed [OPW-1:0] x;
		logic signed [OPW-1:0] y;
		logic                  neg;
	} term_t;

	typedef term_t [3:0] lane_terms_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] row;
		logic       last;
		logic       zero_norm;
	} pass_ctrl_t;

	typedef struct packed {
		logic                      done;
		logic                      zero;
		logic [3:0][OPW-1:0]       res;
	} norm_res_t;

	function automatic term_t mk_term(input logic signed [OPW-1:0] x,
	                                  input logic signed [OPW-1:0] y,
	                                  input logic neg);
		term_t t;
		t.x   = x;
		t.y   = y;
		t.neg = neg;
		return t;
	endfunction

	function automatic logic signed [OPW-1:0] ext(input logic signed [WIDTH-1:0] v);
		return OPW'(v);
	endfunction

endpackage

// ----- rtl/core/qau_lane.sv -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit lane
// Four signed products, registered, then summed, rounded and clamped.
// ----------------------------------------------------------------------------
module qau_lane (
	input  logic                             clk,
	input  logic                             en,
	input  qau_pkg::lane_terms_t             terms,
	output logic signed [qau_pkg::WIDTH-1:0] value,
	output logic                             sat
);
	import qau_pkg::*;

	logic signed [PW-1:0] prod_s2 [4];
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= terms[i].neg ? -(terms[i].x * terms[i].y)
				                           : (terms[i].x * terms[i].y);
			end
		end
	end

	// Round half up to the output grid, then clamp.
	always_comb begin
		sum = SW'(prod_s2[0]) + SW'(prod_s2[1]) + SW'(prod_s2[2]) + SW'(prod_s2[3]);
		rnd = (sum + (SW'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		sat = 1'b0;
		if (rnd > SUM_MAX) begin
			value = SUM_MAX[WIDTH-1:0];
			sat   = 1'b1;
		end else if (rnd < SUM_MIN) begin
			value = SUM_MIN[WIDTH-1:0];
			sat   = 1'b1;
		end else begin
			value = rnd[WIDTH-1:0];
		end
	end

endmodule

// ----- rtl/core/qau_norm.sv -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit normalizer
// Sum of squares, bit-serial square root, four parallel restoring dividers.
// ----------------------------------------------------------------------------
module qau_norm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             ack,
	input  logic signed [qau_pkg::WIDTH-1:0] a [4],
	output qau_pkg::norm_res_t               nres
);
	import qau_pkg::*;

	norm_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] m_q [4];
	logic             neg_q [4];
	logic [SQW-1:0]   s_q;
	logic [RW-1:0]    rem_q;
	logic [NR-1:0]    root_q;
	logic [DW-1:0]    r_q [4];
	logic [DW-1:0]    dsh_q;
	logic [QB-1:0]    quo_q [4];
	logic [RW+1:0]    remx;
	logic [RW+1:0]    trial;
	logic [SQW-1:0]   sqsum;

	always_comb begin
		remx  = {rem_q, s_q[SQW-1 -: 2]};
		trial = (RW+2)'({root_q, 2'b01});
		sqsum = '0;
		for (int i = 0; i < 4; i++) begin
			sqsum = sqsum + SQW'(m_q[i]) * SQW'(m_q[i]);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			NS_IDLE: if (start) state_d = NS_SQR;
			NS_SQR:  state_d = NS_ROOT;
			NS_ROOT: if (cnt_q == '0) state_d = NS_DIV;
			NS_DIV:  if (cnt_q == '0) state_d = NS_DONE;
			NS_DONE: if (ack) state_d = NS_IDLE;
			default: state_d = NS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == NS_SQR) begin
				cnt_q <= CNT_W'(NR - 1);
			end else if (state_q == NS_ROOT && cnt_q == '0) begin
				cnt_q <= CNT_W'(QB - 1);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			NS_IDLE: begin
				for (int i = 0; i < 4; i++) begin
					m_q[i]   <= a[i][WIDTH-1] ? WIDTH'(-a[i]) : WIDTH'(a[i]);
					neg_q[i] <= a[i][WIDTH-1];
					quo_q[i] <= '0;
				end
				rem_q  <= '0;
				root_q <= '0;
			end
			NS_SQR: s_q <= sqsum;
			NS_ROOT: begin
				s_q <= s_q << 2;
				if (remx >= trial) begin
					rem_q  <= RW'(remx - trial);
					root_q <= {root_q[NR-2:0], 1'b1};
				end else begin
					rem_q  <= RW'(remx);
					root_q <= {root_q[NR-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					dsh_q <= DW'({root_q[NR-2:0], (remx >= trial)}) << QB;
					for (int i = 0; i < 4; i++) begin
						r_q[i] <= (DW'(m_q[i]) << (FRAC_BITS + 1))
						          + DW'({root_q[NR-2:0], (remx >= trial)});
					end
				end
			end
			NS_DIV: begin
				dsh_q <= dsh_q >> 1;
				for (int i = 0; i < 4; i++) begin
					if (r_q[i] >= dsh_q) begin
						r_q[i]   <= r_q[i] - dsh_q;
						quo_q[i] <= {quo_q[i][QB-2:0], 1'b1};
					end else begin
						quo_q[i] <= {quo_q[i][QB-2:0], 1'b0};
					end
				end
			end
			NS_DONE: ;
			default: ;
		endcase
	end

	// A zero quaternion leaves a zero root; the dividers then run against a
	// zero divisor, so the result is forced to zero.
	always_comb begin
		nres.done = (state_q == NS_DONE);
		nres.zero = (root_q == '0);
		for (int i = 0; i < 4; i++) begin
			if (nres.zero) begin
				nres.res[i] = '0;
			end else begin
				nres.res[i] = neg_q[i] ? -OPW'(quo_q[i]) : OPW'(quo_q[i]);
			end
		end
	end

endmodule

// ----- rtl/core/qau_merge.sv -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit merge stage
// Joins the lane results and flags into the registered output transfer.
// ----------------------------------------------------------------------------
module qau_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  qau_pkg::pass_ctrl_t              ctrl_s2,
	input  logic signed [qau_pkg::WIDTH-1:0] lane_val [4],
	input  logic [3:0]                       lane_sat,
	output logic                             advance,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [qau_pkg::OUT_W-1:0]        m_axis_tdata, // r_w, r_x, r_y, r_z
	output logic [3:0]                       m_axis_tuser, // row[1:0], saturated, zero_norm
	output logic                             m_axis_tlast
);
	import qau_pkg::*;

	logic                 valid_q;
	logic [OUT_W-1:0]     data_q;
	logic [3:0]           user_q;
	logic                 last_q;

	assign advance = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= ctrl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= {lane_val[3], lane_val[2], lane_val[1], lane_val[0]};
			user_q <= {ctrl_s2.zero_norm, |lane_sat, ctrl_s2.row};
			last_q <= ctrl_s2.last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;
	assign m_axis_tlast  = last_q;

endmodule

// ----- rtl/core/quaternion_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Q3.12 quaternion multiply, add, scale, conjugate, normalize, rotation matrix.
// ----------------------------------------------------------------------------
// Path: a single-pass item goes from the front stage to the lane product registers
// and then to the output register; a normalize item first passes the magnitude
// capture, the sum of squares, the 17-step bit-serial root and the 14-step dividers.
// Throughput: one item per cycle while the output is not stalled, except matrix mode
// (one pass per row) and normalize (the input is held until its pass issues).
// Reset: arst_n clears all valid and state bits; data registers are not reset.
module quaternion_arithmetic_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale, from the lowest bits up.
	input  logic [qau_pkg::IN_W-1:0]    s_axis_tdata,
	// mode.
	input  logic [2:0]                  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// r_w, r_x, r_y, r_z, from the lowest bits up.
	output logic [qau_pkg::OUT_W-1:0]   m_axis_tdata,
	// row[1:0], saturated, zero_norm, from the lowest bits up.
	output logic [3:0]                  m_axis_tuser,
	output logic                        m_axis_tlast
);
	import qau_pkg::*;

	// Front stage: the accepted item waits here while its passes are issued.
	logic                     s1_valid_q;
	mode_t                    s1_mode_q;
	logic signed [WIDTH-1:0]  s1_a_q [4];
	logic signed [WIDTH-1:0]  s1_b_q [4];
	logic signed [WIDTH-1:0]  s1_sc_q;
	logic [1:0]               row_q;

	norm_res_t                nres;
	logic                     advance;
	logic                     issue;
	logic                     pass_last;
	logic                     fire;
	lane_terms_t              terms [4];
	pass_ctrl_t               ctrl_s2_q;
	logic signed [WIDTH-1:0]  lane_val [4];
	logic [3:0]               lane_sat;

	// A normalize item waits for the divider; a matrix item issues one pass
	// per row, and only the final pass frees the front stage.
	assign issue         = s1_valid_q && (s1_mode_q != MODE_NORM || nres.done);
	assign pass_last     = (s1_mode_q != MODE_MAT) || (row_q == 2'd2);
	assign fire          = issue && advance;
	assign s_axis_tready = !s1_valid_q || (fire && pass_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			row_q      <= '0;
		end else begin
			if (s_axis_tready) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (fire) begin
				row_q <= pass_last ? 2'd0 : row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			s1_mode_q <= mode_t'(s_axis_tuser);
			for (int i = 0; i < 4; i++) begin
				s1_a_q[i] <= s_axis_tdata[i*WIDTH +: WIDTH];
				s1_b_q[i] <= s_axis_tdata[(i+4)*WIDTH +: WIDTH];
			end
			s1_sc_q <= s_axis_tdata[8*WIDTH +: WIDTH];
		end
	end

	qau_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s1_valid_q && s1_mode_q == MODE_NORM),
		.ack    (fire && s1_mode_q == MODE_NORM),
		.a      (s1_a_q),
		.nres   (nres)
	);

	// Every mode is mapped onto the lanes as up to four signed product terms
	// per component. Add, conjugate and normalize multiply by one so that the
	// shared rounding and clamping path handles them. Matrix entries carry
	// the factor two in the first operand.
	always_comb begin
		logic signed [OPW-1:0] w, x, y, z;
		logic signed [OPW-1:0] bw, bx, by, bz, sc;
		logic signed [OPW-1:0] x2, y2, z2;
		term_t                 nul, unit;
		w    = ext(s1_a_q[0]);
		x    = ext(s1_a_q[1]);
		y    = ext(s1_a_q[2]);
		z    = ext(s1_a_q[3]);
		bw   = ext(s1_b_q[0]);
		bx   = ext(s1_b_q[1]);
		by   = ext(s1_b_q[2]);
		bz   = ext(s1_b_q[3]);
		sc   = ext(s1_sc_q);
		x2   = x <<< 1;
		y2   = y <<< 1;
		z2   = z <<< 1;
		nul  = mk_term('0, '0, 1'b0);
		unit = mk_term(ONE, ONE, 1'b0);
		for (int l = 0; l < 4; l++) begin
			terms[l] = {nul, nul, nul, nul};
		end
		unique case (s1_mode_q)
			MODE_MUL: begin
				terms[0] = {mk_term(w, bw, 1'b0), mk_term(z, bz, 1'b1),
				            mk_term(y, by, 1'b1), mk_term(x, bx, 1'b1)};
				terms[1] = {mk_term(w, bx, 1'b0), mk_term(z, by, 1'b1),
				            mk_term(y, bz, 1'b0), mk_term(x, bw, 1'b0)};
				terms[2] = {mk_term(w, by, 1'b0), mk_term(z, bx, 1'b0),
				            mk_term(y, bw, 1'b0), mk_term(x, bz, 1'b1)};
				terms[3] = {mk_term(w, bz, 1'b0), mk_term(z, bw, 1'b0),
				            mk_term(y, bx, 1'b1), mk_term(x, by, 1'b0)};
			end
			MODE_ADD: begin
				for (int l = 0; l < 4; l++) begin
					terms[l][0] = mk_term(ext(s1_a_q[l]), ONE, 1'b0);
					terms[l][1] = mk_term(ext(s1_b_q[l]), ONE, 1'b0);
				end
			end
			MODE_SCALE: begin
				for (int l = 0; l < 4; l++) begin
					terms[l][0] = mk_term(ext(s1_a_q[l]), sc, 1'b0);
				end
			end
			MODE_CONJ: begin
				terms[0][0] = mk_term(w, ONE, 1'b0);
				terms[1][0] = mk_term(x, ONE, 1'b1);
				terms[2][0] = mk_term(y, ONE, 1'b1);
				terms[3][0] = mk_term(z, ONE, 1'b1);
			end
			MODE_NORM: begin
				for (int l = 0; l < 4; l++) begin
					terms[l][0] = mk_term($signed(nres.res[l]), ONE, 1'b0);
				end
			end
			MODE_MAT: begin
				unique case (row_q)
					2'd0: begin
						terms[0] = {nul, mk_term(z2, z, 1'b1), mk_term(y2, y, 1'b1), unit};
						terms[1] = {nul, nul, mk_term(z2, w, 1'b1), mk_term(x2, y, 1'b0)};
						terms[2] = {nul, nul, mk_term(y2, w, 1'b0), mk_term(x2, z, 1'b0)};
					end
					2'd1: begin
						terms[0] = {nul, nul, mk_term(z2, w, 1'b0), mk_term(x2, y, 1'b0)};
						terms[1] = {nul, mk_term(z2, z, 1'b1), mk_term(x2, x, 1'b1), unit};
						terms[2] = {nul, nul, mk_term(x2, w, 1'b1), mk_term(y2, z, 1'b0)};
					end
					2'd2: begin
						terms[0] = {nul, nul, mk_term(y2, w, 1'b1), mk_term(x2, z, 1'b0)};
						terms[1] = {nul, nul, mk_term(x2, w, 1'b0), mk_term(y2, z, 1'b0)};
						terms[2] = {nul, mk_term(y2, y, 1'b1), mk_term(x2, x, 1'b1), unit};
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Pass control travels alongside the lane product registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2_q <= '0;
		end else if (advance) begin
			ctrl_s2_q.valid     <= fire;
			ctrl_s2_q.row       <= (s1_mode_q == MODE_MAT) ? row_q : 2'd0;
			ctrl_s2_q.last      <= pass_last;
			ctrl_s2_q.zero_norm <= (s1_mode_q == MODE_NORM) && nres.zero;
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		qau_lane u_lane (
			.clk   (clk),
			.en    (advance),
			.terms (terms[l]),
			.value (lane_val[l]),
			.sat   (lane_sat[l])
		);
	end

	qau_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl_s2       (ctrl_s2_q),
		.lane_val      (lane_val),
		.lane_sat      (lane_sat),
		.advance       (advance),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	`include "quaternion_arithmetic_unit_assert.svh"

	`QAU_ASSERT(a_norm_holds_input, clk, arst_n, (s1_valid_q && s1_mode_q == MODE_NORM && !nres.done) |-> !s_axis_tready, "normalize item released before its result")
	`QAU_ASSERT(a_row_only_in_matrix, clk, arst_n, (s1_valid_q && s1_mode_q != MODE_MAT) |-> (row_q == 2'd0), "row counter moved outside matrix mode")
	`QAU_ASSERT_NEXT(a_row_steps, clk, arst_n, (fire && !pass_last), (s1_valid_q && row_q == $past(row_q) + 2'd1), "matrix row did not advance")
	`QAU_ASSERT(a_nonlast_is_row, clk, arst_n, (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[1:0] != 2'd2 && !m_axis_tuser[3]), "non-final result is not an early matrix row")

endmodule

// ----- test/quaternion_arithmetic_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit testbench
// Sends operand quaternions in every mode through the stream input, predicts
// each result row in fixed point and checks every output transfer in order.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qau_pkg::*;

	// Mode codes that the unit does not use; they give one all-zero result.
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam longint VMAX = (64'sd1 <<< (WIDTH - 1)) - 1;
	localparam longint VMIN = -VMAX - 1;

	typedef struct {
		logic [2:0]            mode;
		logic [3:0][WIDTH-1:0] a;     // w, x, y, z
		logic [3:0][WIDTH-1:0] b;
		logic [WIDTH-1:0]      sc;
	} quat_op_t;

	typedef struct {
		logic [3:0][WIDTH-1:0] r;
		logic [1:0]            row;
		logic                  last;
		logic                  satd;
		logic                  zn;
	} quat_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata = '0;
	logic [2:0]           s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;
	logic [3:0]           m_axis_tuser;
	logic                 m_axis_tlast;

	quat_res_t expected_rows[$];
	int errors = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int hold_off = 0;
	int quiet_cycles = 0;

	quaternion_arithmetic_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Fixed-point prediction. Products are summed exactly in 64 bits, then
	// rounded half up to FRAC_BITS fraction bits and clamped.
	// ------------------------------------------------------------------------
	function automatic logic [WIDTH-1:0] clamp(input longint v, inout logic f);
		if (v > VMAX) begin
			f = 1'b1;
			return WIDTH'(VMAX);
		end
		if (v < VMIN) begin
			f = 1'b1;
			return WIDTH'(VMIN);
		end
		return WIDTH'(v);
	endfunction

	function automatic logic [WIDTH-1:0] round_clamp(input longint v, inout logic f);
		return clamp((v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS, f);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root = 0;
		longint unsigned probe = 64'd1 << 62;
		while (probe > v) probe >>= 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// One rotation matrix entry: optional 1.0, plus or minus 2pq, plus or minus 2rs.
	function automatic logic [WIDTH-1:0] mat_entry(input logic unit, input longint p,
			input longint q, input logic n1, input longint r, input longint s,
			input logic n2, inout logic f);
		longint v;
		v = unit ? (64'sd1 <<< (2 * FRAC_BITS)) : 0;
		v += n1 ? -2 * p * q : 2 * p * q;
		v += n2 ? -2 * r * s : 2 * r * s;
		return round_clamp(v, f);
	endfunction

	function automatic void predict_results(input quat_op_t op);
		longint a[4], b[4], sc, w, x, y, z, m[4], ssq, n, q;
		quat_res_t res;
		logic f;
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'($signed(op.a[i]));
			b[i] = longint'($signed(op.b[i]));
		end
		sc = longint'($signed(op.sc));
		w = a[0]; x = a[1]; y = a[2]; z = a[3];
		res = '{r: '0, row: 2'd0, last: 1'b1, satd: 1'b0, zn: 1'b0};
		f = 1'b0;
		case (op.mode)
			MODE_MUL: begin
				res.r[0] = round_clamp(-x*b[1] - y*b[2] - z*b[3] + w*b[0], f);
				res.r[1] = round_clamp( x*b[0] + y*b[3] - z*b[2] + w*b[1], f);
				res.r[2] = round_clamp(-x*b[3] + y*b[0] + z*b[1] + w*b[2], f);
				res.r[3] = round_clamp( x*b[2] - y*b[1] + z*b[0] + w*b[3], f);
			end
			MODE_ADD: for (int i = 0; i < 4; i++) res.r[i] = clamp(a[i] + b[i], f);
			MODE_SCALE: for (int i = 0; i < 4; i++) res.r[i] = round_clamp(a[i] * sc, f);
			MODE_CONJ: begin
				res.r[0] = op.a[0];
				for (int i = 1; i < 4; i++) res.r[i] = clamp(-a[i], f);
			end
			MODE_NORM: begin
				ssq = 0;
				for (int i = 0; i < 4; i++) begin
					m[i] = a[i] < 0 ? -a[i] : a[i];
					ssq += m[i] * m[i];
				end
				if (ssq == 0) begin
					res.zn = 1'b1;
				end else begin
					n = longint'(int_sqrt(longint'(ssq)));
					for (int i = 0; i < 4; i++) begin
						// Magnitude rounded half away from zero, sign put back after.
						q = (2 * (m[i] <<< FRAC_BITS) + n) / (2 * n);
						res.r[i] = clamp(a[i] < 0 ? -q : q, f);
					end
				end
			end
			MODE_MAT: begin
				quat_res_t rows[3];
				logic rf[3];
				rf = '{1'b0, 1'b0, 1'b0};
				rows[0].r[0] = mat_entry(1'b1, y, y, 1'b1, z, z, 1'b1, rf[0]);
				rows[0].r[1] = mat_entry(1'b0, x, y, 1'b0, z, w, 1'b1, rf[0]);
				rows[0].r[2] = mat_entry(1'b0, x, z, 1'b0, y, w, 1'b0, rf[0]);
				rows[1].r[0] = mat_entry(1'b0, x, y, 1'b0, z, w, 1'b0, rf[1]);
				rows[1].r[1] = mat_entry(1'b1, x, x, 1'b1, z, z, 1'b1, rf[1]);
				rows[1].r[2] = mat_entry(1'b0, y, z, 1'b0, x, w, 1'b1, rf[1]);
				rows[2].r[0] = mat_entry(1'b0, x, z, 1'b0, y, w, 1'b1, rf[2]);
				rows[2].r[1] = mat_entry(1'b0, y, z, 1'b0, x, w, 1'b0, rf[2]);
				rows[2].r[2] = mat_entry(1'b1, x, x, 1'b1, y, y, 1'b1, rf[2]);
				for (int i = 0; i < 3; i++) begin
					rows[i].r[3] = '0;
					rows[i].row = 2'(i);
					rows[i].last = (i == 2);
					rows[i].satd = rf[i];
					rows[i].zn = 1'b0;
					expected_rows.push_back(rows[i]);
				end
				return;
			end
			default: ;
		endcase
		res.satd = f;
		expected_rows.push_back(res);
	endfunction

	// ------------------------------------------------------------------------
	// Sender: one item per call, driven at the falling edge. The task starts and
	// ends on a falling edge, so tvalid is assigned once per edge.
	// ------------------------------------------------------------------------
	task automatic send_item(input quat_op_t op);
		int gap;
		gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 5) : 0;
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {op.sc, op.b, op.a};
		s_axis_tuser  <= op.mode;
		do @(posedge clk); while (!s_axis_tready);
		predict_results(op);
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		while (expected_rows.size() != 0) @(negedge clk);
	endtask

	function automatic quat_op_t make_op(input logic [2:0] mode, input int aw, input int ax,
			input int ay, input int az, input int bw, input int bx, input int by,
			input int bz, input int sc);
		quat_op_t op;
		op.mode = mode;
		op.a = {WIDTH'(az), WIDTH'(ay), WIDTH'(ax), WIDTH'(aw)};
		op.b = {WIDTH'(bz), WIDTH'(by), WIDTH'(bx), WIDTH'(bw)};
		op.sc = WIDTH'(sc);
		return op;
	endfunction

	// Components: full range, values near unit length, or the corner values.
	function automatic logic [WIDTH-1:0] rand_component();
		case ($urandom_range(0, 3))
			0, 1: return WIDTH'($urandom_range(0, 8192)) - WIDTH'(4096);
			2: return WIDTH'($urandom);
			default: case ($urandom_range(0, 4))
				0: return WIDTH'(VMAX);
				1: return WIDTH'(VMIN);
				2: return WIDTH'(1 << FRAC_BITS);
				3: return WIDTH'(-(1 << FRAC_BITS));
				default: return '0;
			endcase
		endcase
	endfunction

	function automatic quat_op_t random_op();
		quat_op_t op;
		op.mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		for (int i = 0; i < 4; i++) begin
			op.a[i] = rand_component();
			op.b[i] = rand_component();
		end
		op.sc = rand_component();
		// Now and then a zero operand, so that normalize meets it.
		if ($urandom_range(0, 24) == 0) op.a = '0;
		return op;
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed();
		int mx, mn;
		mx = int'(VMAX);
		mn = int'(VMIN);
		sender_idle_pct = 12;
		receiver_idle_pct = 68;
		send_item(make_op(MODE_MUL, 4096, 0, 0, 0, 100, -200, 300, -400, 0));
		send_item(make_op(MODE_MUL, 0, 4096, 0, 0, 0, 0, 4096, 0, 0));
		send_item(make_op(MODE_MUL, mx, mx, mx, mx, mx, mx, mx, mx, 0));
		send_item(make_op(MODE_MUL, mn, mn, mn, mn, mn, mx, mn, mx, 0));
		send_item(make_op(MODE_ADD, mx, mn, 1000, -1000, 1, -1, 2000, -3000, 0));
		send_item(make_op(MODE_ADD, mn, mx, 0, -5, mn, mx, 0, 5, 0));
		send_item(make_op(MODE_SCALE, mx, mn, 4096, -1, 0, 0, 0, 0, mn));
		send_item(make_op(MODE_SCALE, 2048, -2048, 1, -1, 0, 0, 0, 0, 1));
		send_item(make_op(MODE_SCALE, mx, mn, 3, -3, 0, 0, 0, 0, mx));
		send_item(make_op(MODE_CONJ, mn, mn, mx, 0, 0, 0, 0, 0, 0));
		send_item(make_op(MODE_CONJ, 123, -456, 789, mn, 0, 0, 0, 0, 0));
		send_item(make_op(MODE_NORM, 0, 0, 0, 0, 7, 7, 7, 7, 7));
		send_item(make_op(MODE_NORM, 4096, 4096, 4096, 4096, 0, 0, 0, 0, 0));
		send_item(make_op(MODE_NORM, mn, mn, mn, mn, 0, 0, 0, 0, 0));
		send_item(make_op(MODE_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_op(MODE_NORM, 0, -1, 1, 0, 0, 0, 0, 0, 0));
		send_item(make_op(MODE_MAT, 4096, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_op(MODE_MAT, 2896, 2896, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_op(MODE_MAT, mx, mx, mx, mx, 0, 0, 0, 0, 0));
		send_item(make_op(MODE_MAT, mn, mn, mn, mn, 0, 0, 0, 0, 0));
		send_item(make_op(MODE_SPARE_6, mx, mn, mx, mn, mx, mn, mx, mn, mx));
		send_item(make_op(MODE_SPARE_7, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		wait_all_results();
	endtask

	task automatic test_random(input int count, input int s_idle, input int r_idle);
		sender_idle_pct = s_idle;
		receiver_idle_pct = r_idle;
		repeat (count) send_item(random_op());
		wait_all_results();
	endtask

	// The receiver stops for a long stretch while items keep coming, so the
	// pipeline fills and the input stalls; afterwards the sender waits for all.
	task automatic test_backpressure();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		hold_off = HOLD_OFF_CYCLES;
		repeat (24) begin
			quat_op_t op;
			op = random_op();
			if (op.mode > MODE_MAT) op.mode = MODE_MUL;
			send_item(op);
		end
		wait_all_results();
	endtask

	// ------------------------------------------------------------------------
	// Receiver readiness, changed at the falling edge.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [WIDTH-1:0] got,
			input logic [WIDTH-1:0] want);
		$display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Result checker: each output transfer against the oldest expected row.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rows.size() == 0) begin
				report_mismatch("unexpected result, tdata low bits",
					m_axis_tdata[WIDTH-1:0], '0);
			end else begin
				quat_res_t want;
				want = expected_rows.pop_front();
				for (int i = 0; i < 4; i++)
					if (m_axis_tdata[i*WIDTH +: WIDTH] !== want.r[i])
						report_mismatch($sformatf("component %0d", i),
							m_axis_tdata[i*WIDTH +: WIDTH], want.r[i]);
				if (m_axis_tuser[1:0] !== want.row)
					report_mismatch("row", WIDTH'(m_axis_tuser[1:0]), WIDTH'(want.row));
				if (m_axis_tuser[2] !== want.satd)
					report_mismatch("saturated", WIDTH'(m_axis_tuser[2]), WIDTH'(want.satd));
				if (m_axis_tuser[3] !== want.zn)
					report_mismatch("zero_norm", WIDTH'(m_axis_tuser[3]), WIDTH'(want.zn));
				if (m_axis_tlast !== want.last)
					report_mismatch("tlast", WIDTH'(m_axis_tlast), WIDTH'(want.last));
			end
		end
	end

	// Watchdog: cycles in which no transfer happens on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(70, 12, 68);
		test_random(70, 68, 12);
		test_random(70, 0, 0);
		test_backpressure();
		test_random(20, 0, 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && expected_rows.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
